>>> design/b64dec_pkg.sv
// types, constants and lookup functions shared by the base64 stream decoder
package b64dec_pkg;

  localparam logic [7:0] CharPad   = 8'h3D;  // '='
  localparam logic [6:0] BadSextet = 7'd64;  // bit 6 marks an invalid character
  localparam logic [7:0] LowNibble = 8'h0F;
  localparam logic [5:0] LowPair   = 6'h03;

  localparam logic KindByte    = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBadChar = 2'd1;
  localparam logic [1:0] StatusSize    = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [15:0] byte_count;
    logic        end_flag;
  } out_item_t;

  // alphabet lookup, invalid characters map to the flagged code
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    begin
      if (c >= 8'h41 && c <= 8'h5A) begin
        v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        v = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
        v = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
        v = 7'd62;
      end else if (c == 8'h2F) begin
        v = 7'd63;
      end else begin
        v = BadSextet;
      end
      return v;
    end
  endfunction

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

>>> design/base64_stream_decoder_top.sv
// base64 stream decoder: one character per transfer in, bytes and a summary out
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | sink      | in_valid_i/in_stall_o | in_data_i (ch, is_last)
//  out     | source    | out_valid_o/out_stall_i | out_data_o (result item)
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_data_i (capacity)
//
// one character is decoded per cycle while in_stall_o is low, in a single
// registered pass: the input transfer updates the quartet state and loads up
// to four results (three bytes and the summary) into a four-entry result
// buffer in the same edge. it drains one result per cycle unless the output
// stalls, so a character yielding at most one result sustains one transfer per
// cycle while unstalled; one yielding more holds further input until the
// single output port drains them. reset clears the capacity and all message
// state but the held sextets; no clearing pass is needed. input stall rises
// only while the buffer holds more than the one result leaving this cycle.
module base64_stream_decoder_top
  import b64dec_pkg::*;
#(
  parameter int unsigned MAX_INPUT_CHARS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // char counter saturates at MAX_INPUT_CHARS + 1
  localparam int CCW  = $clog2(MAX_INPUT_CHARS + 2);
  localparam int CMPW = (CCW > 17) ? CCW : 17;

  // message state
  logic [15:0]    cap_q;
  logic [1:0]     slot_q, slot_d;
  logic           open_q, open_d;
  logic [6:0]     held_q [3];
  logic [15:0]    oc_q, oc_d;
  logic [CCW-1:0] cc_q, cc_d;
  logic           err_q, err_d;
  logic [1:0]     pad_q, pad_d;

  // result buffer, entry 0 is presented on the output
  out_item_t      buf_q [4];
  logic [2:0]     cnt_q;
  out_item_t      res_d [4];
  logic [2:0]     n_d;

  logic in_xfer, out_xfer;
  logic [7:0] ch;
  logic       take, close;
  logic [6:0] v, va, vb, vc, vd;
  logic       bad_ab, emit, e0, e1, e2;
  logic [15:0] oc1, oc2, oc3;
  logic [7:0] b0, b1, b2;
  logic [1:0] lo;
  logic [CCW-1:0]  cc_n;
  logic [1:0]      pad_n;
  logic [CCW+1:0]  cc3;
  logic [CMPW-1:0] expect_q4, cap_pad;
  logic [1:0]      pad_cnt;
  out_item_t       summ;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = buf_q[0];
  assign out_xfer    = out_valid_o && !out_stall_i;
  // free once the last buffered result leaves
  assign in_stall_o  = (cnt_q > 3'd1) || ((cnt_q == 3'd1) && out_stall_i);
  assign in_xfer     = in_valid_i && !in_stall_o;

  assign ch   = in_data_i.ch;
  assign v    = sextet_of(ch);
  assign take = !is_blank(ch);
  // a quartet closes on its fourth character, or at message end with invalid-code fill
  assign close = (take && slot_q == 2'd3) || in_data_i.is_last;

  // quartet as seen at close: held entries, this character, then fill
  always_comb begin
    va = BadSextet;
    vb = BadSextet;
    vc = BadSextet;
    if (slot_q > 2'd0)             va = held_q[0];
    else if (take)                 va = v;
    if (slot_q > 2'd1)             vb = held_q[1];
    else if (take && slot_q == 2'd1) vb = v;
    if (slot_q > 2'd2)             vc = held_q[2];
    else if (take && slot_q == 2'd2) vc = v;
    vd = (take && slot_q == 2'd3) ? v : BadSextet;
  end

  assign bad_ab = va[6] || vb[6];
  assign emit   = close && !err_q && !bad_ab;

  assign b0 = {va[5:0], vb[5:4]};
  assign b1 = (8'({2'b00, vb[5:0]}) & LowNibble) << 4 | 8'(vc[5:2]);
  // invalid third with valid fourth keeps the top bits set
  assign lo = vc[6] ? 2'b11 : 2'((vc[5:0] & LowPair));
  assign b2 = {lo, vd[5:0]};

  // capacity gate, bytes are dropped and not counted once it is reached
  assign e0  = emit && (oc_q < cap_q);
  assign oc1 = oc_q + 16'(e0);
  assign e1  = emit && !vc[6] && (oc1 < cap_q);
  assign oc2 = oc1 + 16'(e1);
  assign e2  = emit && !vd[6] && (oc2 < cap_q);
  assign oc3 = oc2 + 16'(e2);

  assign cc_n  = (cc_q <= CCW'(MAX_INPUT_CHARS)) ? cc_q + CCW'(1) : cc_q;
  assign pad_n = {pad_q[0], ch == CharPad};

  // size check: 3*n/4 - pad > capacity, rearranged to stay unsigned
  assign cc3       = (CCW+2)'({cc_n, 1'b0}) + (CCW+2)'(cc_n);
  assign expect_q4 = CMPW'(cc3[CCW+1:2]);
  assign pad_cnt   = 2'(pad_n[0]) + 2'((cc_n > CCW'(1)) && pad_n[1]);
  assign cap_pad   = CMPW'(cap_q) + CMPW'(pad_cnt);

  always_comb begin
    summ            = '0;
    summ.kind       = KindSummary;
    summ.end_flag   = 1'b1;
    if (cap_q == 16'd0 || cc_n > CCW'(MAX_INPUT_CHARS) || expect_q4 > cap_pad) begin
      summ.status = StatusSize;
    end else if (err_q || (close && bad_ab)) begin
      summ.status = StatusBadChar;
    end else begin
      summ.status     = StatusOk;
      summ.byte_count = oc3;
    end
  end

  // build the result list for this character
  always_comb begin
    out_item_t byte_item;
    for (int i = 0; i < 4; i++) begin
      res_d[i] = '0;
    end
    n_d       = 3'd0;
    byte_item = '0;
    byte_item.kind = KindByte;
    if (e0) begin
      byte_item.data   = b0;
      res_d[n_d[1:0]]  = byte_item;
      n_d              = n_d + 3'd1;
    end
    if (e1) begin
      byte_item.data   = b1;
      res_d[n_d[1:0]]  = byte_item;
      n_d              = n_d + 3'd1;
    end
    if (e2) begin
      byte_item.data   = b2;
      res_d[n_d[1:0]]  = byte_item;
      n_d              = n_d + 3'd1;
    end
    if (in_data_i.is_last) begin
      res_d[n_d[1:0]]  = summ;
      n_d              = n_d + 3'd1;
    end else if (n_d != 3'd0) begin
      res_d[2'(n_d - 3'd1)].end_flag = 1'b1;
    end
  end

  // next message state
  always_comb begin
    err_d  = err_q || (close && !err_q && bad_ab);
    slot_d = slot_q;
    open_d = open_q;
    oc_d   = oc3;
    cc_d   = cc_n;
    pad_d  = pad_n;
    if (close) begin
      slot_d = 2'd0;
      open_d = 1'b0;
    end else if (take) begin
      slot_d = slot_q + 2'd1;
      open_d = 1'b1;
    end else if (slot_q == 2'd0) begin
      // whitespace at a quartet boundary still opens one
      open_d = 1'b1;
    end
    if (in_data_i.is_last) begin
      oc_d  = '0;
      cc_d  = '0;
      pad_d = '0;
      err_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= '0;
      slot_q <= '0;
      open_q <= 1'b0;
      oc_q   <= '0;
      cc_q   <= '0;
      err_q  <= 1'b0;
      pad_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (in_xfer) begin
        slot_q <= slot_d;
        open_q <= open_d;
        oc_q   <= oc_d;
        cc_q   <= cc_d;
        err_q  <= err_d;
        pad_q  <= pad_d;
      end
    end
  end

  // held sextets are written before they are read
  always_ff @(posedge clk_i) begin
    if (in_xfer && take && !close && slot_q != 2'd3) begin
      held_q[slot_q] <= v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_xfer) begin
      cnt_q <= n_d;
    end else if (out_xfer) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < 4; i++) begin
        buf_q[i] <= res_d[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < 3; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("result buffer overfilled");

  a_stall_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (cnt_q <= 3'd1)) else $error("input taken over pending results");

  a_summary_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindSummary |-> out_data_o.end_flag)
    else $error("summary without end flag");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindByte
      |-> (out_data_o.status == StatusOk && out_data_o.byte_count == 16'd0))
    else $error("byte result carries summary fields");

  a_slot_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q != 2'd0 |-> open_q) else $error("held sextets without open quartet");

endmodule
